>>> sv/gbz_pkg.sv
// Shared types and constants for the zero-padded Gaussian blur.
// Used by gbz_div and gaussian_blur_zero_pad; depends on nothing.
package gbz_pkg;

  // Fixed-point constants of the weight generator
  localparam int unsigned LOG2_E272_Q16 = 94608;
  localparam int unsigned RECIP_SHIFT   = 38;
  localparam int unsigned FRAC_STEPS    = 12;

  // Shared divider widths (numerator holds 2^38 + S - 1, denominator holds S)
  localparam int unsigned DIV_NW = 40;
  localparam int unsigned DIV_DW = 24;

  // Configuration register indices
  localparam logic [1:0] CFG_SIGMA  = 2'd0;
  localparam logic [1:0] CFG_RADIUS = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    P_IDLE,
    P_TAP,
    P_DRAIN,
    P_MUL,
    P_OUT
  } pix_state_t;

  typedef enum logic [2:0] {
    RB_IDLE,
    RB_WSTART,
    RB_WDIV,
    RB_WPOW,
    RB_WSTORE,
    RB_SUM,
    RB_RSTART,
    RB_RDIV
  } rb_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  // 2^(-2^-(k+1)) in Q30
  function automatic logic [29:0] pow_frac(input logic [3:0] k);
    logic [29:0] v;
    case (k)
      4'd0:    v = 30'd759250125;
      4'd1:    v = 30'd902905697;
      4'd2:    v = 30'd984625594;
      4'd3:    v = 30'd1028218693;
      4'd4:    v = 30'd1050733751;
      4'd5:    v = 30'd1062175488;
      4'd6:    v = 30'd1067942999;
      4'd7:    v = 30'd1070838486;
      4'd8:    v = 30'd1072289172;
      4'd9:    v = 30'd1073015252;
      4'd10:   v = 30'd1073378477;
      4'd11:   v = 30'd1073560134;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/gbz_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gbz_pkg for widths and request/response structs.
module gbz_div (
  input  logic              clk,
  input  logic              rst,
  input  gbz_pkg::div_req_t req,
  output gbz_pkg::div_rsp_t rsp
);
  import gbz_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] q;
  logic              done;
  logic [DIV_DW:0]   trial;
  logic              take;

  // trial subtract of the next numerator bit
  always_comb begin
    trial = {rem, q[DIV_NW-1]};
    take  = (trial >= {1'b0, req.den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.num;
      rem <= '0;
    end else if (busy) begin
      rem <= take ? DIV_DW'(trial - {1'b0, req.den}) : DIV_DW'(trial);
      q   <= {q[DIV_NW-2:0], take};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = q;

  // a result only ever follows a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a division in flight");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("divider restarted while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0))
    else $error("divider count ran out while busy");

endmodule

>>> sv/gaussian_blur_zero_pad.sv
// Top level of the zero-padded Gaussian blur: line memory, tap sequencer, weight builder.
// Depends on gbz_pkg and gbz_div.
//
// Usage:
//   s_axis carries raster pixels (tdata) and a flush flag (tuser); a flush transaction
//   stands for a zero pad and pushes the window past the frame end. m_axis carries the
//   filtered pixel (tdata) with tlast on the last pixel of the frame.
//   Output lags input by r*W + r transactions; the first r*W + r of a frame give nothing.
//   Each transaction that yields a result has the tap sequencer walk all (2r+1)^2 taps
//   through the single read port of the line memory, one tap per cycle, then pass the
//   drain, multiply and output states; one that yields nothing leaves the sequencer idle.
//   Config writes: sigma or radius rebuild the weight table and reciprocal with
//   s_axis_tready low; radius, width or height also return the position to the
//   frame start.
//   Reset runs the same rebuild for sigma 1, r 1, 512 x 512.
//   The result register decouples the sides: the next pixel is accepted while a result
//   waits; the sequencer only holds when a second result is ready and m_axis stalls.
module gaussian_blur_zero_pad #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  input  logic        s_axis_tuser,   // [0] flush
  // filtered output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic        m_axis_tlast    // frame_last
);
  import gbz_pkg::*;

  localparam int WIN_MAX    = 2 * MAX_RADIUS + 1;
  localparam int WTAB_DEPTH = 2 * MAX_RADIUS * MAX_RADIUS + 1;
  localparam int RING_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int RA_W       = $clog2(RING_DEPTH);
  localparam int T_W        = $clog2(WIN_MAX);
  localparam int D_W        = $clog2(WTAB_DEPTH);
  localparam int CW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int RW         = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int P_W        = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_RADIUS + 1) + 1);
  localparam int ACC_W      = 24 + $clog2(WIN_MAX * WIN_MAX);
  localparam int PROD_W     = ACC_W + 24;
  localparam int DN_W       = $clog2(WTAB_DEPTH * LOG2_E272_Q16);

  // configuration registers
  logic [3:0]  blur_sigma;
  logic [1:0]  kernel_radius;
  logic [10:0] image_width;
  logic [10:0] image_height;

  // effective geometry
  logic [1:0]      r_eff;
  logic [CW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [RA_W-1:0] delay_v;
  logic [RA_W-1:0] span_v;
  logic [RA_W:0]   row_inc;

  always_comb begin
    r_eff = (int'(kernel_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : kernel_radius;
    if (image_width == '0)                     w_eff = CW'(1);
    else if (int'(image_width) > MAX_WIDTH)    w_eff = CW'(MAX_WIDTH);
    else                                       w_eff = CW'(image_width);
    if (image_height == '0)                    h_eff = HW'(1);
    else if (int'(image_height) > MAX_HEIGHT)  h_eff = HW'(MAX_HEIGHT);
    else                                       h_eff = HW'(image_height);
    delay_v = RA_W'(RA_W'(r_eff) * RA_W'(w_eff)) + RA_W'(r_eff);
    span_v  = RA_W'({delay_v, 1'b0});
    // step from the last tap of one row to the first of the next, modulo the ring
    if ((RA_W+1)'(w_eff) >= (RA_W+1)'({r_eff, 1'b0}))
      row_inc = (RA_W+1)'(w_eff) - (RA_W+1)'({r_eff, 1'b0});
    else
      row_inc = (RA_W+1)'(RING_DEPTH) + (RA_W+1)'(w_eff) - (RA_W+1)'({r_eff, 1'b0});
  end

  // squared distance of tap (a, b) from the window centre
  function automatic logic [D_W-1:0] sq_dist(input logic [T_W-1:0] a,
                                             input logic [T_W-1:0] b,
                                             input logic [1:0] r);
    logic [T_W-1:0] da;
    logic [T_W-1:0] db;
    da = (a >= T_W'(r)) ? a - T_W'(r) : T_W'(r) - a;
    db = (b >= T_W'(r)) ? b - T_W'(r) : T_W'(r) - b;
    return D_W'(D_W'(da) * D_W'(da) + D_W'(db) * D_W'(db));
  endfunction

  // ---------------------------------------------------------------- weight builder
  rb_state_t       rb_state;
  logic [D_W-1:0]  wb_d;
  logic [31:0]     e_q;
  logic [30:0]     pacc;
  logic [3:0]      kstep;
  logic [T_W-1:0]  si;
  logic [T_W-1:0]  sj;
  logic [23:0]     wsum;
  logic [23:0]     recip;
  logic [15:0]     wtab [WTAB_DEPTH];
  logic [D_W-1:0]  wt_addr;
  logic [15:0]     wt_rd;
  logic [23:0]     wsum_nz;
  logic [15:0]     wnew;
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic [T_W-1:0]  two_r;

  assign two_r   = T_W'({r_eff, 1'b0});
  assign wsum_nz = (wsum == '0) ? 24'd1 : wsum;

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    if (rb_state == RB_WSTART && blur_sigma != '0) begin
      dreq.start = 1'b1;
      dreq.num   = DIV_NW'(DN_W'(wb_d) * DN_W'(LOG2_E272_Q16));
      dreq.den   = DIV_DW'({8'(blur_sigma) * 8'(blur_sigma), 1'b0});
    end else if (rb_state == RB_RSTART) begin
      dreq.start = 1'b1;
      dreq.num   = (DIV_NW'(1) << RECIP_SHIFT) + DIV_NW'(wsum_nz) - DIV_NW'(1);
      dreq.den   = DIV_DW'(wsum_nz);
    end else if (rb_state == RB_RDIV) begin
      dreq.den   = DIV_DW'(wsum_nz);
    end else begin
      dreq.den   = DIV_DW'({8'(blur_sigma) * 8'(blur_sigma), 1'b0});
    end
  end

  gbz_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // weight from exponent: integer part shifts, fraction product already in pacc
  always_comb begin
    if (e_q[31:16] >= 16'd16) wnew = '0;
    else                      wnew = 16'(pacc >> (5'd15 + 5'(e_q[19:16])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rb_state      <= RB_WSTART;
      wb_d          <= '0;
      blur_sigma    <= 4'd1;
      kernel_radius <= 2'd1;
      image_width   <= 11'd512;
      image_height  <= 11'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIGMA: begin
          blur_sigma <= cfg_data[3:0];
          rb_state   <= RB_WSTART;
          wb_d       <= '0;
        end
        CFG_RADIUS: begin
          kernel_radius <= cfg_data[1:0];
          rb_state      <= RB_WSTART;
          wb_d          <= '0;
        end
        CFG_WIDTH:  image_width  <= cfg_data;
        CFG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end else begin
      case (rb_state)
        RB_WSTART: begin
          if (blur_sigma == '0) begin
            if (wb_d == D_W'(WTAB_DEPTH - 1)) rb_state <= RB_SUM;
            else                              wb_d <= wb_d + 1'b1;
          end else begin
            rb_state <= RB_WDIV;
          end
        end
        RB_WDIV:   if (drsp.done) rb_state <= RB_WPOW;
        RB_WPOW:   if (kstep == 4'(FRAC_STEPS - 1)) rb_state <= RB_WSTORE;
        RB_WSTORE: begin
          if (wb_d == D_W'(WTAB_DEPTH - 1)) begin
            rb_state <= RB_SUM;
          end else begin
            wb_d     <= wb_d + 1'b1;
            rb_state <= RB_WSTART;
          end
        end
        RB_SUM:    if (si == two_r && sj == two_r) rb_state <= RB_RSTART;
        RB_RSTART: rb_state <= RB_RDIV;
        RB_RDIV:   if (drsp.done) rb_state <= RB_IDLE;
        default:   rb_state <= RB_IDLE;
      endcase
    end
  end

  // weight builder datapath
  always_ff @(posedge clk) begin
    case (rb_state)
      RB_WSTART: begin
        if (blur_sigma == '0) wtab[wb_d] <= (wb_d == '0) ? 16'd32768 : 16'd0;
        si   <= '0;
        sj   <= '0;
        wsum <= '0;
      end
      RB_WDIV: begin
        e_q   <= drsp.quo[31:0];
        pacc  <= 31'd1 << 30;
        kstep <= '0;
      end
      RB_WPOW: begin
        if (e_q[4'd15 - kstep])
          pacc <= 31'((62'(pacc) * 62'(pow_frac(kstep))) >> 30);
        kstep <= kstep + 1'b1;
      end
      RB_WSTORE: begin
        wtab[wb_d] <= wnew;
        si   <= '0;
        sj   <= '0;
        wsum <= '0;
      end
      RB_SUM: begin
        wsum <= wsum + 24'(wt_rd);
        if (sj == two_r) begin
          sj <= '0;
          si <= si + 1'b1;
        end else begin
          sj <= sj + 1'b1;
        end
      end
      RB_RDIV: if (drsp.done) recip <= drsp.quo[23:0];
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- pixel path
  pix_state_t      p_state;
  logic [7:0]      ring [RING_DEPTH];
  logic [RA_W-1:0] wr_ptr;
  logic [RA_W-1:0] taddr;
  logic [7:0]      rd_data;
  logic [CW-1:0]   in_col;
  logic [RW-1:0]   in_row;
  logic [P_W-1:0]  pcnt;
  logic [CW-1:0]   ocol;
  logic [RW-1:0]   orow;
  logic [T_W-1:0]  ti;
  logic [T_W-1:0]  tj;
  logic            tap_v;
  logic            tap_ok;
  logic [D_W-1:0]  tap_d;
  logic [ACC_W-1:0] acc;
  logic [PROD_W-1:0] prod;
  logic            last_q;
  logic            in_acc;
  logic [7:0]      pix;
  logic            emit;
  logic            is_last;
  logic [RA_W-1:0] start_addr;
  logic [RA_W:0]   next_row_addr;
  logic [RA_W-1:0] next_col_addr;
  logic [RW:0]     rr_ext;
  logic [CW:0]     cc_ext;
  logic            bound_ok;
  logic            out_load;
  logic [PROD_W-1:0] res_full;
  logic [7:0]      res_sat;
  logic            geo_reset;

  assign s_axis_tready = (p_state == P_IDLE) && (rb_state == RB_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wt_addr       = (rb_state == RB_SUM) ? sq_dist(si, sj, r_eff) : tap_d;
  assign wt_rd         = wtab[wt_addr];
  assign geo_reset     = cfg_we && (cfg_index == CFG_RADIUS || cfg_index == CFG_WIDTH ||
                                    cfg_index == CFG_HEIGHT);

  always_comb begin
    pix     = (in_row < RW'(h_eff) && !s_axis_tuser) ? s_axis_tdata : 8'd0;
    emit    = (pcnt >= P_W'(delay_v));
    is_last = emit && (orow == RW'(h_eff - 1'b1)) && (ocol == w_eff - 1'b1);
    start_addr = (wr_ptr >= span_v) ? wr_ptr - span_v
                                    : RA_W'((RA_W+1)'(wr_ptr) + (RA_W+1)'(RING_DEPTH)
                                            - (RA_W+1)'(span_v));
    next_row_addr = (RA_W+1)'(taddr) + row_inc;
    if (next_row_addr >= (RA_W+1)'(RING_DEPTH))
      next_row_addr = next_row_addr - (RA_W+1)'(RING_DEPTH);
    next_col_addr = (taddr == RA_W'(RING_DEPTH - 1)) ? '0 : taddr + 1'b1;
    rr_ext   = (RW+1)'(orow) + (RW+1)'(ti);
    cc_ext   = (CW+1)'(ocol) + (CW+1)'(tj);
    bound_ok = (rr_ext >= (RW+1)'(r_eff)) && (rr_ext < (RW+1)'(h_eff) + (RW+1)'(r_eff)) &&
               (cc_ext >= (CW+1)'(r_eff)) && (cc_ext < (CW+1)'(w_eff) + (CW+1)'(r_eff));
    res_full = prod >> RECIP_SHIFT;
    res_sat  = (res_full > PROD_W'(255)) ? 8'd255 : res_full[7:0];
    out_load = (p_state == P_OUT) && (!m_axis_tvalid || m_axis_tready);
  end

  // line memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc) ring[wr_ptr] <= pix;
    rd_data <= ring[taddr];
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      p_state <= P_IDLE;
      wr_ptr  <= '0;
      in_col  <= '0;
      in_row  <= '0;
      pcnt    <= '0;
      ocol    <= '0;
      orow    <= '0;
      tap_v   <= 1'b0;
    end else begin
      tap_v <= (p_state == P_TAP);
      if (geo_reset) begin
        in_col <= '0;
        in_row <= '0;
        pcnt   <= '0;
        ocol   <= '0;
        orow   <= '0;
      end else begin
        case (p_state)
          P_IDLE: begin
            if (in_acc) begin
              wr_ptr <= (wr_ptr == RA_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
              if (is_last) begin
                in_col <= '0;
                in_row <= '0;
                pcnt   <= '0;
              end else begin
                pcnt <= pcnt + 1'b1;
                if (in_col + 1'b1 >= w_eff) begin
                  in_col <= '0;
                  in_row <= in_row + 1'b1;
                end else begin
                  in_col <= in_col + 1'b1;
                end
              end
              if (emit) p_state <= P_TAP;
            end
          end
          P_TAP:   if (ti == two_r && tj == two_r) p_state <= P_DRAIN;
          P_DRAIN: p_state <= P_MUL;
          P_MUL:   p_state <= P_OUT;
          P_OUT: begin
            if (out_load) begin
              p_state <= P_IDLE;
              if (last_q) begin
                ocol <= '0;
                orow <= '0;
              end else if (ocol + 1'b1 >= w_eff) begin
                ocol <= '0;
                orow <= orow + 1'b1;
              end else begin
                ocol <= ocol + 1'b1;
              end
            end
          end
          default: p_state <= P_IDLE;
        endcase
      end
    end
  end

  // tap walk and accumulation
  always_ff @(posedge clk) begin
    if (p_state == P_IDLE && in_acc) begin
      taddr  <= start_addr;
      ti     <= '0;
      tj     <= '0;
      acc    <= '0;
      last_q <= is_last;
    end else if (p_state == P_TAP) begin
      if (tj == two_r) begin
        tj    <= '0;
        ti    <= ti + 1'b1;
        taddr <= RA_W'(next_row_addr);
      end else begin
        tj    <= tj + 1'b1;
        taddr <= next_col_addr;
      end
    end
    tap_ok <= bound_ok;
    tap_d  <= sq_dist(ti, tj, r_eff);
    if (tap_v && tap_ok) acc <= acc + ACC_W'(rd_data) * ACC_W'(wt_rd);
    if (p_state == P_MUL) prod <= PROD_W'(acc) * PROD_W'(recip);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res_sat;
      m_axis_tlast <= last_q;
    end
  end

  // no pixel enters while the weights are being rebuilt
  a_no_accept_in_rebuild: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (rb_state == RB_IDLE))
    else $error("pixel accepted during weight rebuild");
  // the tap address stays inside the ring
  a_tap_in_ring: assert property (@(posedge clk) disable iff (rst)
    (p_state == P_TAP) |-> (taddr < RA_W'(RING_DEPTH)))
    else $error("tap address outside line memory");
  // a finished result waits while the output is still stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (p_state == P_OUT && m_axis_tvalid && !m_axis_tready) |=> (p_state == P_OUT))
    else $error("result overwrote a stalled output");
  // the walk ends after the last tap and always drains before the multiply
  a_drain_then_mul: assert property (@(posedge clk) disable iff (rst || geo_reset)
    (p_state == P_DRAIN) |=> (p_state == P_MUL))
    else $error("sequencer skipped the multiply stage");

endmodule
